// ===== src/tcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, pipeline stage positions and payload types for the
// tetrahedron circumsphere core. No dependencies.
package tcs_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LEN_W   = 68;
   localparam int CR_W    = 67;
   localparam int DET_W   = 104;
   localparam int NUM_W   = 140;

   localparam int LIMB_W  = 32;
   localparam int MUL_W   = 160;
   localparam int LIMBS   = MUL_W / LIMB_W;
   localparam int PP_LVLS = $clog2(LIMBS * LIMBS);
   localparam int PP_N    = 1 << PP_LVLS;
   localparam int MUL_LAT = PP_LVLS + 3;

   localparam int DIV_W   = 140;
   localparam int QUO_W   = 35;
   localparam int DIVX_W  = DIV_W + QUO_W;
   localparam int DIV_LAT = QUO_W + 1;

   localparam int SQ_W     = 272;
   localparam int SQX_W    = SQ_W + 2;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int SQRT_LAT = ROOT_W;

   localparam int CEN_W = QUO_W + 2;

   localparam int ST_DIFF = 0;
   localparam int ST_M1   = ST_DIFF + MUL_LAT;
   localparam int ST_A1   = ST_M1 + 1;
   localparam int ST_M2   = ST_A1 + MUL_LAT;
   localparam int ST_A2   = ST_M2 + 1;
   localparam int ST_A3   = ST_A2 + 1;
   localparam int ST_A4   = ST_A3 + 1;
   localparam int ST_A5   = ST_A4 + 1;
   localparam int ST_CDIV = ST_A5 + DIV_LAT;
   localparam int ST_CEN  = ST_CDIV + 1;
   localparam int ST_SMUL = ST_A3 + MUL_LAT;
   localparam int ST_SSUM = ST_SMUL + 1;
   localparam int ST_ROOT = ST_SSUM + SQRT_LAT;
   localparam int ST_RDIV = ST_ROOT + DIV_LAT;
   localparam int ST_OUT  = ST_RDIV + 1;
   localparam int PIPE_N  = ST_OUT + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [COORD_W-1:0] radius_type;
   typedef logic signed [MUL_W-1:0]   mul_in_type;
   typedef logic signed [2*MUL_W-1:0] mul_out_type;

endpackage

// ===== src/tcs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the circumsphere core: corner points in, sphere out.
// Depends on tcs_pkg.
interface tcs_req_if;
   logic               valid;
   logic               ready;
   tcs_pkg::coord_type p0_x, p0_y, p0_z;
   tcs_pkg::coord_type p1_x, p1_y, p1_z;
   tcs_pkg::coord_type p2_x, p2_y, p2_z;
   tcs_pkg::coord_type p3_x, p3_y, p3_z;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                   p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                 p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface tcs_rsp_if;
   logic                valid;
   logic                ready;
   tcs_pkg::coord_type  center_x, center_y, center_z;
   tcs_pkg::radius_type radius;
   logic                degenerate;

   modport source (output valid, center_x, center_y, center_z, radius, degenerate,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, radius, degenerate,
                 output ready);
endinterface

// ===== src/tcs_mul.sv =====
`timescale 1ns / 1ps
// Pipelined signed multiplier: 32x32 limb products and a registered adder tree.
// Depends on tcs_pkg.
module tcs_mul (
   input  logic                 clock,
   input  logic                 en,
   input  tcs_pkg::mul_in_type  a,
   input  tcs_pkg::mul_in_type  b,
   output tcs_pkg::mul_out_type p
);
   import tcs_pkg::*;

   logic [MUL_W-1:0]    mag_a_in, mag_b_in;
   logic [MUL_W-1:0]    mag_a_ff, mag_b_ff;
   logic [2*LIMB_W-1:0] limb_in [LIMBS*LIMBS];
   logic [2*MUL_W-1:0]  pp_ff [PP_N];
   logic [2*MUL_W-1:0]  sum_ff [PP_LVLS][PP_N/2];
   logic                neg_ff [PP_LVLS+2];
   mul_out_type         p_ff;

   always_comb begin
      mag_a_in = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
      mag_b_in = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            limb_in[i*LIMBS+j] = (2*LIMB_W)'(mag_a_ff[i*LIMB_W +: LIMB_W])
                               * (2*LIMB_W)'(mag_b_ff[j*LIMB_W +: LIMB_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff  <= mag_a_in;
         mag_b_ff  <= mag_b_in;
         neg_ff[0] <= a[MUL_W-1] ^ b[MUL_W-1];
         for (int n = 1; n < PP_LVLS + 2; n++) begin
            neg_ff[n] <= neg_ff[n-1];
         end
         for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
               pp_ff[i*LIMBS+j] <= (2*MUL_W)'(limb_in[i*LIMBS+j]) << (LIMB_W * (i + j));
            end
         end
         for (int k = LIMBS * LIMBS; k < PP_N; k++) begin
            pp_ff[k] <= '0;
         end
         for (int k = 0; k < PP_N / 2; k++) begin
            sum_ff[0][k] <= pp_ff[2*k] + pp_ff[2*k+1];
         end
         for (int l = 1; l < PP_LVLS; l++) begin
            for (int k = 0; k < (PP_N >> (l + 1)); k++) begin
               sum_ff[l][k] <= sum_ff[l-1][2*k] + sum_ff[l-1][2*k+1];
            end
         end
         p_ff <= neg_ff[PP_LVLS+1] ? -$signed(sum_ff[PP_LVLS-1][0])
                                   : $signed(sum_ff[PP_LVLS-1][0]);
      end
   end

   assign p = p_ff;

endmodule

// ===== src/tcs_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on tcs_pkg.
module tcs_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tcs_pkg::DIV_W-1:0]   num,
   input  logic [tcs_pkg::DIV_W-1:0]   den,
   output logic [tcs_pkg::QUO_W-1:0]   quo
);
   import tcs_pkg::*;

   logic [DIVX_W-1:0] rem_ff [QUO_W+1];
   logic [DIV_W-1:0]  den_ff [QUO_W+1];
   logic [QUO_W-1:0]  q_ff   [QUO_W+1];
   logic              ovf_ff [QUO_W+1];
   logic [DIVX_W-1:0] trial  [QUO_W];
   logic              take   [QUO_W];

   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         trial[s] = DIVX_W'(den_ff[s]) << (QUO_W - 1 - s);
         take[s]  = rem_ff[s] >= trial[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DIVX_W'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= DIVX_W'(num) >= (DIVX_W'(den) << QUO_W);
         for (int s = 0; s < QUO_W; s++) begin
            rem_ff[s+1] <= take[s] ? rem_ff[s] - trial[s] : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
            q_ff[s+1]   <= q_ff[s] | (take[s] ? QUO_W'(1) << (QUO_W - 1 - s) : '0);
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quo = ovf_ff[QUO_W] ? '1 : q_ff[QUO_W];

endmodule

// ===== src/tcs_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on tcs_pkg.
module tcs_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tcs_pkg::SQ_W-1:0]    s,
   output logic [tcs_pkg::ROOT_W-1:0]  root
);
   import tcs_pkg::*;

   logic [SQX_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SQX_W-1:0]  rem_src  [ROOT_W];
   logic [ROOT_W-1:0] root_src [ROOT_W];
   logic [SQX_W-1:0]  trial    [ROOT_W];
   logic              take     [ROOT_W];

   always_comb begin
      rem_src[0]  = SQX_W'(s);
      root_src[0] = '0;
      for (int t = 1; t < ROOT_W; t++) begin
         rem_src[t]  = rem_ff[t-1];
         root_src[t] = root_ff[t-1];
      end
      for (int t = 0; t < ROOT_W; t++) begin
         trial[t] = (SQX_W'(root_src[t]) << (ROOT_W - t))
                  | (SQX_W'(1) << (2 * (ROOT_W - 1 - t)));
         take[t]  = rem_src[t] >= trial[t];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < ROOT_W; t++) begin
            rem_ff[t]  <= take[t] ? rem_src[t] - trial[t] : rem_src[t];
            root_ff[t] <= root_src[t] | (take[t] ? ROOT_W'(1) << (ROOT_W - 1 - t) : '0);
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// ===== src/tetrahedron_circumsphere_core.sv =====
`timescale 1ns / 1ps
// Top level of the tetrahedron circumsphere core.
// Depends on tcs_pkg, tcs_if, tcs_mul, tcs_div and tcs_sqrt.
//
// Usage:
//   req_if carries four corner points, signed Q16.16; rsp_if returns the
//   circumcentre (signed Q16.16, saturated), the radius (unsigned Q16.16,
//   saturated) and a degenerate flag, set with all other fields zero when
//   the points are coplanar. An item moves on a cycle with valid and ready
//   both high.
//   The depth of the pipeline is set by the 136-stage square root and the
//   36-stage divider on the radius path.
//   Throughput: one item per cycle. Every stage advances together; a
//   result waits in the output register while the receiver holds ready low,
//   and req_if.ready then stays low until that result is taken, so nothing
//   is lost or repeated. Bubbles ride through as invalid slots.
//   Reset clears all valid bits; data registers are not reset.
module tetrahedron_circumsphere_core (
   input  logic       clock,
   input  logic       reset,
   tcs_req_if.sink    req_if,
   tcs_rsp_if.source  rsp_if
);
   import tcs_pkg::*;

   logic                     adv;
   logic [PIPE_N-1:0]        vld_ff;
   coord_type                pt [4][3];

   logic signed [DIFF_W-1:0] d_ff   [3][3];
   coord_type                ref_ff [ST_CDIV+1][3];
   logic signed [DIFF_W-1:0] d0_ff  [ST_A1][3];

   mul_out_type              sq_p  [3][3];
   mul_out_type              cpa_p [3][3];
   mul_out_type              cpb_p [3][3];
   logic signed [LEN_W-1:0]  len_ff [3];
   logic signed [CR_W-1:0]   cr_ff  [3][3];

   mul_out_type              det_p [3];
   mul_out_type              nm_p  [3][3];
   logic signed [DET_W-1:0]  det_ff;
   logic signed [NUM_W-1:0]  num_ff  [3];
   logic signed [DET_W-1:0]  detr_ff [ST_ROOT-ST_A3+1];
   logic signed [NUM_W-1:0]  numf_ff [3];
   logic                     degen_ff [ST_RDIV-ST_A3+1];

   logic signed [NUM_W-1:0]  n_ff [3];
   logic [DIV_W-1:0]         dd_ff;
   logic [DIV_W-1:0]         m_ff [3];
   logic [DIV_W-1:0]         den5_ff;
   logic                     cneg_ff [DIV_LAT+1][3];
   logic [QUO_W-1:0]         cq [3];
   logic signed [CEN_W-1:0]  csum [3];
   coord_type                cen_in [3];
   coord_type                cen_ff [ST_RDIV-ST_CEN+1][3];

   mul_out_type              s_p [3];
   logic [SQ_W-1:0]          ssum_ff;
   logic [ROOT_W-1:0]        root;
   logic [QUO_W-1:0]         rq;
   logic [QUO_W:0]           rsum;
   radius_type               rad_in;

   coord_type                cx_ff, cy_ff, cz_ff;
   radius_type               rad_ff;
   logic                     dgn_ff;

   assign pt[0][0] = req_if.p0_x;
   assign pt[0][1] = req_if.p0_y;
   assign pt[0][2] = req_if.p0_z;
   assign pt[1][0] = req_if.p1_x;
   assign pt[1][1] = req_if.p1_y;
   assign pt[1][2] = req_if.p1_z;
   assign pt[2][0] = req_if.p2_x;
   assign pt[2][1] = req_if.p2_y;
   assign pt[2][2] = req_if.p2_z;
   assign pt[3][0] = req_if.p3_x;
   assign pt[3][1] = req_if.p3_y;
   assign pt[3][2] = req_if.p3_z;

   assign adv          = !vld_ff[ST_OUT] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_N-2:0], req_if.valid};
      end
   end

   // edge vectors from the fourth corner
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               d_ff[i][k] <= DIFF_W'(pt[i][k]) - DIFF_W'(pt[3][k]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            ref_ff[0][k] <= pt[3][k];
            d0_ff[0][k]  <= d_ff[0][k];
         end
         for (int n = 1; n <= ST_CDIV; n++) begin
            ref_ff[n] <= ref_ff[n-1];
         end
         for (int n = 1; n < ST_A1; n++) begin
            d0_ff[n] <= d0_ff[n-1];
         end
      end
   end

   // squared lengths and cross products, then determinant, numerator and radius products
   for (genvar gi = 0; gi < 3; gi++) begin : g_m1
      for (genvar gk = 0; gk < 3; gk++) begin : g_k
         tcs_mul u_sq (
            .clock (clock), .en (adv),
            .a (MUL_W'(d_ff[gi][gk])), .b (MUL_W'(d_ff[gi][gk])), .p (sq_p[gi][gk]));
         tcs_mul u_cpa (
            .clock (clock), .en (adv),
            .a (MUL_W'(d_ff[(gi+1)%3][(gk+1)%3])), .b (MUL_W'(d_ff[(gi+2)%3][(gk+2)%3])),
            .p (cpa_p[gi][gk]));
         tcs_mul u_cpb (
            .clock (clock), .en (adv),
            .a (MUL_W'(d_ff[(gi+1)%3][(gk+2)%3])), .b (MUL_W'(d_ff[(gi+2)%3][(gk+1)%3])),
            .p (cpb_p[gi][gk]));
         tcs_mul u_nm (
            .clock (clock), .en (adv),
            .a (MUL_W'(len_ff[gi])), .b (MUL_W'(cr_ff[gi][gk])), .p (nm_p[gi][gk]));
      end
      tcs_mul u_det (
         .clock (clock), .en (adv),
         .a (MUL_W'(d0_ff[ST_A1-1][gi])), .b (MUL_W'(cr_ff[0][gi])), .p (det_p[gi]));
      tcs_mul u_s (
         .clock (clock), .en (adv),
         .a (MUL_W'(numf_ff[gi])), .b (MUL_W'(numf_ff[gi])), .p (s_p[gi]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            len_ff[i] <= LEN_W'(sq_p[i][0]) + LEN_W'(sq_p[i][1]) + LEN_W'(sq_p[i][2]);
            for (int k = 0; k < 3; k++) begin
               cr_ff[i][k] <= CR_W'(cpa_p[i][k]) - CR_W'(cpb_p[i][k]);
            end
         end
         det_ff <= DET_W'(det_p[0]) + DET_W'(det_p[1]) + DET_W'(det_p[2]);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= NUM_W'(nm_p[0][k]) + NUM_W'(nm_p[1][k]) + NUM_W'(nm_p[2][k]);
         end
      end
   end

   // make the determinant positive, then form rounded division operands
   always_ff @(posedge clock) begin
      if (adv) begin
         detr_ff[0]  <= det_ff[DET_W-1] ? -det_ff : det_ff;
         degen_ff[0] <= det_ff == '0;
         for (int k = 0; k < 3; k++) begin
            numf_ff[k] <= det_ff[DET_W-1] ? -num_ff[k] : num_ff[k];
            n_ff[k]    <= numf_ff[k] + NUM_W'(detr_ff[0]);
            m_ff[k]    <= n_ff[k][NUM_W-1] ? DIV_W'(-n_ff[k]) + dd_ff - DIV_W'(1)
                                           : DIV_W'(n_ff[k]);
            cneg_ff[0][k] <= n_ff[k][NUM_W-1];
         end
         dd_ff   <= DIV_W'(detr_ff[0]) << 1;
         den5_ff <= dd_ff;
         for (int n = 1; n <= ST_ROOT - ST_A3; n++) begin
            detr_ff[n] <= detr_ff[n-1];
         end
         for (int n = 1; n <= ST_RDIV - ST_A3; n++) begin
            degen_ff[n] <= degen_ff[n-1];
         end
         for (int n = 1; n <= DIV_LAT; n++) begin
            cneg_ff[n] <= cneg_ff[n-1];
         end
      end
   end

   for (genvar gk = 0; gk < 3; gk++) begin : g_cdiv
      tcs_div u_cdiv (
         .clock (clock), .en (adv), .num (m_ff[gk]), .den (den5_ff), .quo (cq[gk]));
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         csum[k] = cneg_ff[DIV_LAT][k] ? CEN_W'(ref_ff[ST_CDIV][k]) - CEN_W'({1'b0, cq[k]})
                                       : CEN_W'(ref_ff[ST_CDIV][k]) + CEN_W'({1'b0, cq[k]});
         if ((&csum[k][CEN_W-1:COORD_W-1]) || !(|csum[k][CEN_W-1:COORD_W-1])) begin
            cen_in[k] = csum[k][COORD_W-1:0];
         end else if (csum[k][CEN_W-1]) begin
            cen_in[k] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            cen_in[k] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cen_ff[0] <= cen_in;
         for (int n = 1; n <= ST_RDIV - ST_CEN; n++) begin
            cen_ff[n] <= cen_ff[n-1];
         end
         ssum_ff <= SQ_W'(s_p[0]) + SQ_W'(s_p[1]) + SQ_W'(s_p[2]);
      end
   end

   // radius: round(isqrt(|N|^2) / a / 2)
   tcs_sqrt u_sqrt (.clock (clock), .en (adv), .s (ssum_ff), .root (root));

   tcs_div u_rdiv (
      .clock (clock), .en (adv), .num (DIV_W'(root)),
      .den (DIV_W'(detr_ff[ST_ROOT-ST_A3])), .quo (rq));

   always_comb begin
      rsum = {1'b0, rq} + (QUO_W+1)'(1);
      if (|rsum[QUO_W:COORD_W+1]) begin
         rad_in = '1;
      end else begin
         rad_in = rsum[COORD_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dgn_ff <= degen_ff[ST_RDIV-ST_A3];
         if (degen_ff[ST_RDIV-ST_A3]) begin
            cx_ff  <= '0;
            cy_ff  <= '0;
            cz_ff  <= '0;
            rad_ff <= '0;
         end else begin
            cx_ff  <= cen_ff[ST_RDIV-ST_CEN][0];
            cy_ff  <= cen_ff[ST_RDIV-ST_CEN][1];
            cz_ff  <= cen_ff[ST_RDIV-ST_CEN][2];
            rad_ff <= rad_in;
         end
      end
   end

   assign rsp_if.valid      = vld_ff[ST_OUT];
   assign rsp_if.center_x   = cx_ff;
   assign rsp_if.center_y   = cy_ff;
   assign rsp_if.center_z   = cz_ff;
   assign rsp_if.radius     = rad_ff;
   assign rsp_if.degenerate = dgn_ff;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.degenerate |->
         rsp_if.center_x == '0 && rsp_if.center_y == '0 &&
         rsp_if.center_z == '0 && rsp_if.radius == '0)
      else $error("degenerate item with non-zero result");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_last_stage : assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[ST_OUT-1] |=> rsp_if.valid)
      else $error("item lost before output register");

endmodule
